// ----- rtl/core/lidar_line_direction_binner_assert.svh -----
// Assertion macros used by the binner RTL.
// Clock clk_i and active-low reset rst_ni are assumed in the using scope.
`ifndef LIDAR_LINE_DIRECTION_BINNER_ASSERT_SVH
`define LIDAR_LINE_DIRECTION_BINNER_ASSERT_SVH

// Check that a property holds at every clock edge outside reset.
`define LLDB_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("%m: property violated");

// Check that a condition never holds outside reset.
`define LLDB_ASSERT_NEVER(name, cond) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("%m: forbidden condition seen");

`endif

// ----- rtl/core/lldb_pkg.sv -----
package lldb_pkg;

  localparam int unsigned BinCount = 4;
  localparam int unsigned BinW     = 2;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned LsqW     = 33;

  localparam logic signed [17:0] PiQ12 = 18'sd12861;

  localparam logic [CfgIdxW-1:0] CfgFrontAngle  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgRightAngle  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRightOffset = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgFrontOffset = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTolerance   = 3'd4;

  localparam logic signed [15:0] FrontAngleRst  = 16'sd12861;
  localparam logic signed [15:0] RightAngleRst  = 16'sd6431;
  localparam logic signed [15:0] RightOffsetRst = 16'sd397;
  localparam logic signed [15:0] FrontOffsetRst = 16'sd0;
  localparam logic [14:0]        ToleranceRst   = 15'd1229;

  localparam logic [BinW-1:0] BinRight = 2'd0;
  localparam logic [BinW-1:0] BinLeft  = 2'd1;
  localparam logic [BinW-1:0] BinFront = 2'd2;
  localparam logic [BinW-1:0] BinBack  = 2'd3;

  typedef struct packed {
    logic              func;
    logic signed [15:0] start_x;
    logic signed [15:0] start_y;
    logic signed [15:0] end_x;
    logic signed [15:0] end_y;
    logic signed [15:0] radius;
    logic signed [15:0] angle;
  } in_t;

  typedef struct packed {
    logic [1:0]         direction;
    logic signed [15:0] distance;
    logic signed [15:0] bin_angle;
    logic               last;
  } out_t;

  typedef struct packed {
    logic signed [15:0] front_angle;
    logic signed [15:0] right_angle;
    logic [14:0]        tolerance;
  } ang_cfg_t;

  typedef struct packed {
    logic            hit;
    logic [BinW-1:0] bin;
    logic            straddle;
  } cls_t;

  function automatic logic [17:0] abs18(input logic signed [17:0] v);
    abs18 = v[17] ? 18'(-v) : 18'(v);
  endfunction

  function automatic logic signed [15:0] sat16(input logic signed [16:0] v);
    if (v > 17'sd32767) begin
      sat16 = 16'sh7fff;
    end else if (v < -17'sd32768) begin
      sat16 = 16'sh8000;
    end else begin
      sat16 = v[15:0];
    end
  endfunction

  function automatic logic is_pos(input logic signed [15:0] v);
    is_pos = !v[15] && (v != 16'sd0);
  endfunction

endpackage

// ----- rtl/core/lidar_line_direction_binner.sv -----
// Direction binner for extracted lidar line segments. One transaction enters per
// cycle on the input channel; a segment passes through the input register, the
// classify/square stage and the bin update stage, and produces no result. An
// end-of-frame transaction snapshots the four bins into the output buffer,
// clears them, and then yields four result transactions, right, left, front,
// back, one per cycle while out_ready_i is high, the fourth flagged last. A
// second end of frame waits in the update stage until the previous four results
// have been taken; the transaction behind it holds in the input register and the
// input stalls until then. Configuration writes are accepted every cycle and
// must only be issued while the block is idle.
`include "lidar_line_direction_binner_assert.svh"

module lidar_line_direction_binner
  import lldb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  in_t                in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output out_t               out_data_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  ang_cfg_t           ang_cfg_q;
  logic signed [15:0] roff_q, foff_q;

  logic s1_valid_q, s1_go;
  in_t  s1_data_q;
  cls_t s1_cls;
  logic [15:0] adx, ady;

  logic               s2_valid_q, s2_go, s2_free;
  logic               s2_func_q;
  cls_t               s2_cls_q;
  logic [31:0]        s2_sqx_q, s2_sqy_q;
  logic signed [15:0] s2_rad_q, s2_ang_q;
  logic [LsqW-1:0]    lsq;

  logic [LsqW-1:0]    best_q   [BinCount];
  logic               locked_q [BinCount];
  logic signed [15:0] krad_q   [BinCount];
  logic signed [15:0] kang_q   [BinCount];

  logic               emit_busy_q;
  logic [BinW-1:0]    emit_cnt_q;
  logic signed [15:0] odist_q [BinCount];
  logic signed [15:0] oang_q  [BinCount];
  logic               out_acc;
  logic               any_locked;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ang_cfg_q.front_angle <= FrontAngleRst;
      ang_cfg_q.right_angle <= RightAngleRst;
      ang_cfg_q.tolerance   <= ToleranceRst;
      roff_q                <= RightOffsetRst;
      foff_q                <= FrontOffsetRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgFrontAngle:  ang_cfg_q.front_angle <= cfg_data_i;
        CfgRightAngle:  ang_cfg_q.right_angle <= cfg_data_i;
        CfgRightOffset: roff_q                <= cfg_data_i;
        CfgFrontOffset: foff_q                <= cfg_data_i;
        CfgTolerance:   ang_cfg_q.tolerance   <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  // Pipeline control
  assign s2_go      = s2_valid_q && !(s2_func_q && emit_busy_q);
  assign s2_free    = !s2_valid_q || s2_go;
  assign s1_go      = s1_valid_q && s2_free;
  assign in_ready_o = !s1_valid_q || s1_go;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        s1_valid_q <= 1'b1;
      end else if (s1_go) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_go) begin
        s2_valid_q <= 1'b1;
      end else if (s2_go) begin
        s2_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s1_data_q <= in_data_i;
    end
  end

  // Stage 1: classify and square the endpoint deltas
  lldb_classify u_classify (
    .item_i (s1_data_q),
    .cfg_i  (ang_cfg_q),
    .cls_o  (s1_cls)
  );

  always_comb begin
    logic signed [16:0] dx, dy;
    dx  = 17'(s1_data_q.start_x) - 17'(s1_data_q.end_x);
    dy  = 17'(s1_data_q.start_y) - 17'(s1_data_q.end_y);
    adx = dx[16] ? 16'(-dx) : dx[15:0];
    ady = dy[16] ? 16'(-dy) : dy[15:0];
  end

  always_ff @(posedge clk_i) begin
    if (s1_go) begin
      s2_func_q <= s1_data_q.func;
      s2_cls_q  <= s1_cls;
      s2_sqx_q  <= adx * adx;
      s2_sqy_q  <= ady * ady;
      s2_rad_q  <= s1_data_q.radius;
      s2_ang_q  <= s1_data_q.angle;
    end
  end

  // Stage 2: bin update or frame snapshot
  assign lsq = {1'b0, s2_sqx_q} + {1'b0, s2_sqy_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < BinCount; k++) begin
        best_q[k]   <= '0;
        locked_q[k] <= 1'b0;
        krad_q[k]   <= '0;
        kang_q[k]   <= '0;
      end
    end else if (s2_go) begin
      if (s2_func_q) begin
        for (int k = 0; k < BinCount; k++) begin
          best_q[k]   <= '0;
          locked_q[k] <= 1'b0;
          krad_q[k]   <= '0;
          kang_q[k]   <= '0;
        end
      end else if (s2_cls_q.hit) begin
        if (s2_cls_q.straddle) begin
          locked_q[s2_cls_q.bin] <= 1'b1;
          krad_q[s2_cls_q.bin]   <= s2_rad_q;
          kang_q[s2_cls_q.bin]   <= s2_ang_q;
        end else if (!locked_q[s2_cls_q.bin] && (lsq > best_q[s2_cls_q.bin])) begin
          best_q[s2_cls_q.bin] <= lsq;
          krad_q[s2_cls_q.bin] <= s2_rad_q;
          kang_q[s2_cls_q.bin] <= s2_ang_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_go && s2_func_q) begin
      odist_q[BinRight] <= sat16(17'(krad_q[BinRight]) - 17'(roff_q));
      odist_q[BinLeft]  <= sat16(17'(krad_q[BinLeft]) + 17'(roff_q));
      odist_q[BinFront] <= sat16(17'(krad_q[BinFront]) - 17'(foff_q));
      odist_q[BinBack]  <= sat16(17'(krad_q[BinBack]) + 17'(foff_q));
      for (int k = 0; k < BinCount; k++) begin
        oang_q[k] <= kang_q[k];
      end
    end
  end

  // Result emission
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      emit_busy_q <= 1'b0;
      emit_cnt_q  <= '0;
    end else if (s2_go && s2_func_q) begin
      emit_busy_q <= 1'b1;
      emit_cnt_q  <= '0;
    end else if (out_acc) begin
      emit_cnt_q <= emit_cnt_q + 1'b1;
      if (emit_cnt_q == BinBack) begin
        emit_busy_q <= 1'b0;
      end
    end
  end

  assign out_valid_o          = emit_busy_q;
  assign out_data_o.direction = emit_cnt_q;
  assign out_data_o.distance  = odist_q[emit_cnt_q];
  assign out_data_o.bin_angle = oang_q[emit_cnt_q];
  assign out_data_o.last      = (emit_cnt_q == BinBack);

  assign any_locked = locked_q[BinRight] || locked_q[BinLeft] ||
                      locked_q[BinFront] || locked_q[BinBack];

  `LLDB_ASSERT(a_idle_cnt_zero, !emit_busy_q |-> (emit_cnt_q == '0))
  `LLDB_ASSERT(a_frame_clears, (s2_go && s2_func_q) |=> (emit_busy_q && !any_locked))
  `LLDB_ASSERT(a_last_ends_emit, (out_acc && out_data_o.last) |=> !emit_busy_q)
  `LLDB_ASSERT_NEVER(a_stall_without_item, !in_ready_o && !s1_valid_q)

endmodule

// ----- rtl/core/lldb_classify.sv -----
module lldb_classify
  import lldb_pkg::*;
(
  input  in_t      item_i,
  input  ang_cfg_t cfg_i,
  output cls_t     cls_o
);

  logic signed [17:0] ang, fa, ra;
  logic signed [17:0] d_fp, d_fm, d_fpi, d_rm, d_rpi;
  logic [17:0]        tol;
  logic               front_hit, right_hit;

  assign ang   = 18'(item_i.angle);
  assign fa    = 18'(cfg_i.front_angle);
  assign ra    = 18'(cfg_i.right_angle);
  assign tol   = {3'b000, cfg_i.tolerance};

  assign d_fp  = ang + fa;
  assign d_fm  = ang - fa;
  assign d_fpi = ang - fa + PiQ12;
  assign d_rm  = ang - ra;
  assign d_rpi = ang - ra + PiQ12;

  assign front_hit = (abs18(d_fp) < tol) || (abs18(d_fm) < tol) || (abs18(d_fpi) < tol);
  assign right_hit = (abs18(d_rm) < tol) || (abs18(d_rpi) < tol);

  always_comb begin
    cls_o.hit      = front_hit || right_hit;
    cls_o.bin      = BinRight;
    cls_o.straddle = 1'b0;
    if (front_hit) begin
      cls_o.bin      = is_pos(item_i.start_x) ? BinLeft : BinRight;
      cls_o.straddle = (item_i.start_y[15] && is_pos(item_i.end_y)) ||
                       (is_pos(item_i.start_y) && item_i.end_y[15]);
    end else if (right_hit) begin
      cls_o.bin      = is_pos(item_i.start_y) ? BinBack : BinFront;
      cls_o.straddle = (item_i.start_x[15] && is_pos(item_i.end_x)) ||
                       (is_pos(item_i.start_x) && item_i.end_x[15]);
    end
  end

endmodule
